// File: rtl/flht_pkg.sv
package flht_pkg;

    // Field widths of the sample, the result and the configuration port.
    localparam int TEMP_W     = 8;
    localparam int RPM_W      = 13;
    localparam int LEVEL_W    = 3;
    localparam int ENTRY_W    = 61;
    localparam int CFG_IDX_W  = 3;

    // Default number of fan levels in the table.
    localparam int LEVELS_DEFAULT = 7;

    // One table row, laid out as the configuration word (bit 0 is on_chg[0]).
    typedef struct packed {
        logic        [RPM_W-1:0]  rpm;
        logic signed [TEMP_W-1:0] off_soc;
        logic signed [TEMP_W-1:0] off_mem;
        logic signed [TEMP_W-1:0] off_chg;
        logic signed [TEMP_W-1:0] on_soc;
        logic signed [TEMP_W-1:0] on_mem;
        logic signed [TEMP_W-1:0] on_chg;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic inc;
        logic dec;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fell;
        logic rose;
        logic up_go;
        logic down_go;
        logic out_free;
    } t_status;

endpackage

// File: rtl/flht_in_if.sv
interface flht_in_if
    import flht_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_charger;
    logic signed [TEMP_W-1:0] temp_memory;
    logic signed [TEMP_W-1:0] temp_soc;
    logic                     system_active;

    modport source (
        output valid, temp_charger, temp_memory, temp_soc, system_active,
        input  ready
    );

    modport sink (
        input  valid, temp_charger, temp_memory, temp_soc, system_active,
        output ready
    );
endinterface

// File: rtl/flht_out_if.sv
interface flht_out_if
    import flht_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RPM_W-1:0]   fan_rpm;
    logic [LEVEL_W-1:0] fan_level;

    modport source (
        output valid, fan_rpm, fan_level,
        input  ready
    );

    modport sink (
        input  valid, fan_rpm, fan_level,
        output ready
    );
endinterface

// File: rtl/flht_ctrl.sv
module flht_ctrl
    import flht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_active,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIR  = 3'd1;
    localparam logic [2:0] ST_UP   = 3'd2;
    localparam logic [2:0] ST_DOWN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // A sample is taken only when no other is in flight.
    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_active) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIR;
                end
            end
            ST_DIR: begin
                if (i_status.fell) begin
                    n_state = ST_DOWN;
                end else if (i_status.rose) begin
                    n_state = ST_UP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_UP: begin
                if (i_status.up_go) begin
                    o_cmd.inc = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DOWN: begin
                if (i_status.down_go) begin
                    o_cmd.dec = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/flht_dp.sv
module flht_dp
    import flht_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ENTRY_W-1:0]       i_cfg_data,
    input  logic signed [TEMP_W-1:0] i_temp_charger,
    input  logic signed [TEMP_W-1:0] i_temp_memory,
    input  logic signed [TEMP_W-1:0] i_temp_soc,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [RPM_W-1:0]         o_fan_rpm,
    output logic [LEVEL_W-1:0]       o_fan_level
);

    localparam int LVL_W = $clog2(LEVELS);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);
    localparam logic [CFG_IDX_W-1:0] ROWS = CFG_IDX_W'(LEVELS);

    t_entry                   r_table [LEVELS];
    logic [LEVEL_W-1:0]       r_level_now;
    logic [LEVEL_W-1:0]       r_walk;
    logic signed [TEMP_W-1:0] r_t_chg;
    logic signed [TEMP_W-1:0] r_t_mem;
    logic signed [TEMP_W-1:0] r_t_soc;
    logic signed [TEMP_W-1:0] r_last_chg;
    logic signed [TEMP_W-1:0] r_last_mem;
    logic signed [TEMP_W-1:0] r_last_soc;
    logic                     r_out_valid;
    logic [RPM_W-1:0]         r_out_rpm;
    logic [LEVEL_W-1:0]       r_out_level;

    t_entry                   row;
    logic                     up_cond;
    logic                     down_cond;

    // Level table; rows past the last level are not stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_table[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < ROWS)) begin
            r_table[i_cfg_index[LVL_W-1:0]] <= t_entry'(i_cfg_data);
        end
    end

    // The row under the walking level and its threshold tests.
    assign row       = r_table[r_walk[LVL_W-1:0]];
    assign up_cond   = ((r_t_chg > row.on_chg) && (r_t_mem > row.on_mem)) ||
                       (r_t_soc > row.on_soc);
    assign down_cond = (r_t_chg < row.off_chg) && (r_t_mem < row.off_mem) &&
                       (r_t_soc < row.off_soc);

    // Status towards the controller.
    always_comb begin
        o_status.fell     = (r_t_chg < r_last_chg) || (r_t_mem < r_last_mem) ||
                            (r_t_soc < r_last_soc);
        o_status.rose     = (r_t_chg > r_last_chg) || (r_t_mem > r_last_mem) ||
                            (r_t_soc > r_last_soc);
        o_status.up_go    = up_cond && (r_walk < TOP_LEVEL);
        o_status.down_go  = down_cond && (r_walk != '0);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // Sample capture and the level walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t_chg <= i_temp_charger;
            r_t_mem <= i_temp_memory;
            r_t_soc <= i_temp_soc;
            r_walk  <= r_level_now;
        end else if (i_cmd.inc) begin
            r_walk <= r_walk + LEVEL_W'(1);
        end else if (i_cmd.dec) begin
            r_walk <= r_walk - LEVEL_W'(1);
        end
    end

    // Remembered level and temperatures, updated when a sample completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_now <= '0;
            r_last_chg  <= '0;
            r_last_mem  <= '0;
            r_last_soc  <= '0;
        end else if (i_cmd.commit) begin
            r_level_now <= r_walk;
            r_last_chg  <= r_t_chg;
            r_last_mem  <= r_t_mem;
            r_last_soc  <= r_t_soc;
        end
    end

    // Output register; it holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rpm   <= row.rpm;
            r_out_level <= r_walk;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fan_rpm   = r_out_rpm;
    assign o_fan_level = r_out_level;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level_now <= TOP_LEVEL)
        else $error("stored fan level beyond the table");

    a_inc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc |-> r_walk < TOP_LEVEL)
        else $error("level walk stepped past the top");

    a_dec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dec |-> r_walk != '0)
        else $error("level walk stepped below zero");

    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid && (r_out_level == r_level_now))
        else $error("result does not match the stored level");
`endif

endmodule

// File: rtl/fan_level_hysteresis_table.sv
// Fan level selector with hysteresis. Each transfer on i_in carries three
// temperatures and a system-active flag; an inactive sample is taken and
// dropped without a result. For an active sample the block compares the
// temperatures with the previous sample and walks the current level down
// (all three below the row's off thresholds) or up (charger and memory above
// their on thresholds, or SoC above its own) one table row per cycle, through
// a single row multiplexer and one set of comparators. The result is
// registered on o_out after the DIR and DONE states when the temperatures
// are unchanged, and after DIR, the walk and DONE when they moved and the
// level walks k steps (k from 0 to LEVELS - 1), so the length of the walk
// and any result still waiting in the output register set the time. The
// next sample can be taken in the cycle the result appears in the output
// register. A finished result waits in the output register while a new
// sample is worked on; if it is still waiting when the next result is
// ready, that result and the input stall until its transfer. Table rows
// are written through i_cfg_we, i_cfg_index and i_cfg_data, one 61-bit row
// per write, and should only be changed while idle.
module fan_level_hysteresis_table
    import flht_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ENTRY_W-1:0]   i_cfg_data,
    flht_in_if.sink              i_in,
    flht_out_if.source           o_out
);

    t_cmd    cmd;
    t_status status;

    // Sequencer for one sample at a time.
    flht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_active   (i_in.system_active),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // Table, level state and output register.
    flht_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_temp_charger (i_in.temp_charger),
        .i_temp_memory  (i_in.temp_memory),
        .i_temp_soc     (i_in.temp_soc),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_fan_rpm      (o_out.fan_rpm),
        .o_fan_level    (o_out.fan_level)
    );

endmodule
